>>> rtl/core/hat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the header attribute tokenizer.
// No dependencies.
package hat_pkg;
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NAME     = 2'd0;
  localparam logic [1:0] ERR_VALUE    = 2'd1;
  localparam logic [1:0] ERR_QUOTED   = 2'd2;
  localparam logic [1:0] ERR_UNTERM   = 2'd3;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // Command from the front end to the emitter.
  typedef enum logic [1:0] {
    CMD_ATTR  = 2'd0,
    CMD_ERROR = 2'd1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] name_len;
    logic [5:0] value_len;
    logic [1:0] code;
  } cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/hat_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue between the parser front end and the emitter.
// Depends on hat_pkg.
module hat_cmd_fifo
  import hat_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  input  cmd_t push_cmd,
  output logic full,
  output logic empty,
  input  wire  pop,
  output cmd_t head
);
  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/hat_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: replays buffered name and value bytes of one command, then the end
// or error beat. Reads the front end's stores. Depends on hat_pkg.
module hat_emitter
  import hat_pkg::*;
#(
  parameter int NAME_LIMIT  = 16,
  parameter int VALUE_LIMIT = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cmd_empty,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       busy,
  output logic [4:0] name_addr,
  input  wire  [7:0] name_data,
  output logic [5:0] value_addr,
  input  wire  [7:0] value_data,
  output logic       valid,
  input  wire        stall,
  output logic [1:0] item_kind,
  output logic [7:0] out_byte,
  output logic [1:0] error_code,
  output logic       last_of_run
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_NAME,
    S_VALUE,
    S_TAIL
  } state_t;

  state_t     state;
  logic [5:0] idx;
  logic [5:0] idx_next;
  logic       take;

  assign busy       = (state != S_IDLE);
  // Store reads are registered: present the index needed next cycle.
  assign name_addr  = idx_next[4:0];
  assign value_addr = idx_next;
  assign take       = !valid || !stall;
  assign cmd_pop    = take && (state == S_TAIL);

  always_comb begin
    idx_next = idx;
    if (take) begin
      case (state)
        S_IDLE:  idx_next = 6'd0;
        S_NAME:  idx_next = (idx[4:0] >= cmd.name_len) ? 6'd0 : idx + 6'd1;
        S_VALUE: idx_next = (idx >= cmd.value_len) ? idx : idx + 6'd1;
        default: idx_next = idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      idx   <= 6'd0;
    end else if (take) begin
      valid <= 1'b0;
      idx   <= idx_next;
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            state <= (cmd.kind == CMD_ERROR) ? S_TAIL : S_NAME;
          end
        end
        S_NAME: begin
          if (idx[4:0] >= cmd.name_len) begin
            state <= S_VALUE;
          end else begin
            valid       <= 1'b1;
            item_kind   <= KIND_NAME;
            out_byte    <= name_data;
            error_code  <= 2'd0;
            last_of_run <= 1'b0;
          end
        end
        S_VALUE: begin
          if (idx >= cmd.value_len) begin
            state <= S_TAIL;
          end else begin
            valid       <= 1'b1;
            item_kind   <= KIND_VALUE;
            out_byte    <= value_data;
            error_code  <= 2'd0;
            last_of_run <= 1'b0;
          end
        end
        S_TAIL: begin
          valid       <= 1'b1;
          item_kind   <= (cmd.kind == CMD_ERROR) ? KIND_ERROR : KIND_END;
          out_byte    <= 8'd0;
          error_code  <= (cmd.kind == CMD_ERROR) ? cmd.code : 2'd0;
          last_of_run <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/hat_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: classifies header bytes, fills the name and value stores and
// queues attribute or error commands. Depends on hat_pkg.
module hat_parser
  import hat_pkg::*;
#(
  parameter int NAME_LIMIT  = 16,
  parameter int VALUE_LIMIT = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        valid,
  output logic       stall,
  input  wire  [7:0] header_byte,
  input  wire        end_of_header,
  input  wire        emit_busy,
  input  wire        cmd_full,
  input  wire        cmd_empty,
  output logic       cmd_push,
  output cmd_t       cmd_out,
  input  wire  [4:0] name_raddr,
  output logic [7:0] name_rdata,
  input  wire  [5:0] value_raddr,
  output logic [7:0] value_rdata
);
  typedef enum logic [1:0] {
    M_NAME,
    M_VALUE,
    M_IGNORE
  } mode_t;

  logic [7:0] name_store  [NAME_LIMIT];
  logic [7:0] value_store [VALUE_LIMIT];

  mode_t      mode, mode_next;
  logic       in_quotes, in_quotes_next;
  logic       quote_dbl, quote_dbl_next;
  logic [4:0] name_len, name_len_next;
  logic [5:0] value_len, value_len_next;
  logic [5:0] trim_len, trim_len_next;
  logic       dropping, dropping_next;

  logic       is_ws, is_ctl, is_delim, acc;
  logic       nwr, vwr, push_c, reset_all, err;
  logic [1:0] ecode;
  cmd_t       c;
  logic [7:0] ch;

  assign ch    = header_byte;
  // Buffers are shared with the emitter: wait while it replays.
  assign stall = emit_busy || !cmd_empty || cmd_full;
  assign acc   = valid && !stall;

  always_comb begin
    is_ws    = (ch == CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0D);
    is_ctl   = (ch < 8'h20) || (ch == 8'h7F);
    is_delim = (ch == CH_SEMI) || (ch == CH_COMMA);
    mode_next      = mode;
    in_quotes_next = in_quotes;
    quote_dbl_next = quote_dbl;
    name_len_next  = name_len;
    value_len_next = value_len;
    trim_len_next  = trim_len;
    dropping_next  = dropping;
    nwr = 1'b0;
    vwr = 1'b0;
    push_c = 1'b0;
    err = 1'b0;
    ecode = ERR_NAME;
    reset_all = 1'b0;
    c = '{kind: CMD_ATTR, name_len: name_len, value_len: 6'd0, code: 2'd0};
    if (dropping) begin
      reset_all = end_of_header;
    end else begin
      case (mode)
        M_NAME: begin
          if (ch == CH_EQ) begin
            in_quotes_next = 1'b0;
            quote_dbl_next = 1'b0;
            value_len_next = 6'd0;
            trim_len_next  = 6'd0;
            mode_next      = M_VALUE;
          end else if (is_delim) begin
            if (name_len != 5'd0) begin
              push_c = 1'b1;
              name_len_next = 5'd0;
              value_len_next = 6'd0;
              trim_len_next = 6'd0;
            end
          end else if (!is_ws) begin
            if (is_ctl || 32'(name_len) >= NAME_LIMIT) begin
              err = 1'b1;
              ecode = ERR_NAME;
            end else begin
              nwr = 1'b1;
              name_len_next = name_len + 5'd1;
            end
          end
        end
        M_VALUE: begin
          if (!in_quotes) begin
            if (is_delim) begin
              push_c = 1'b1;
              c.value_len = trim_len;
              name_len_next = 5'd0;
              value_len_next = 6'd0;
              trim_len_next = 6'd0;
              mode_next = M_NAME;
            end else if (value_len == 6'd0 && (ch == CH_SQUOTE || ch == CH_DQUOTE)) begin
              in_quotes_next = 1'b1;
              quote_dbl_next = (ch == CH_DQUOTE);
            end else if (ch == CH_SPACE || ch == CH_TAB) begin
              if (value_len != 6'd0) begin
                if (32'(value_len) >= VALUE_LIMIT) begin
                  err = 1'b1;
                  ecode = ERR_VALUE;
                end else begin
                  vwr = 1'b1;
                  value_len_next = value_len + 6'd1;
                end
              end
            end else if (is_ctl || 32'(value_len) >= VALUE_LIMIT) begin
              err = 1'b1;
              ecode = ERR_VALUE;
            end else begin
              vwr = 1'b1;
              value_len_next = value_len + 6'd1;
              trim_len_next = value_len + 6'd1;
            end
          end else begin
            if (ch == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
              push_c = 1'b1;
              c.value_len = value_len;
              name_len_next = 5'd0;
              value_len_next = 6'd0;
              trim_len_next = 6'd0;
              in_quotes_next = 1'b0;
              quote_dbl_next = 1'b0;
              mode_next = M_IGNORE;
            end else if (32'(value_len) >= VALUE_LIMIT) begin
              err = 1'b1;
              ecode = ERR_QUOTED;
            end else begin
              vwr = 1'b1;
              value_len_next = value_len + 6'd1;
            end
          end
        end
        M_IGNORE: begin
          if (is_delim) begin
            mode_next = M_NAME;
          end
        end
        default: mode_next = M_NAME;
      endcase
      if (err) begin
        push_c = 1'b1;
        c = '{kind: CMD_ERROR, name_len: 5'd0, value_len: 6'd0, code: ecode};
        if (end_of_header) begin
          reset_all = 1'b1;
        end else begin
          dropping_next = 1'b1;
        end
      end else if (end_of_header) begin
        // A byte ends at most one run, so at most one command per beat.
        reset_all = 1'b1;
        if (name_len_next != 5'd0) begin
          push_c = 1'b1;
          if (mode_next == M_VALUE && in_quotes_next) begin
            c = '{kind: CMD_ERROR, name_len: 5'd0, value_len: 6'd0, code: ERR_UNTERM};
          end else if (mode_next == M_VALUE) begin
            c = '{kind: CMD_ATTR, name_len: name_len_next, value_len: trim_len_next,
                  code: 2'd0};
          end else if (mode_next == M_NAME) begin
            c = '{kind: CMD_ATTR, name_len: name_len_next, value_len: 6'd0, code: 2'd0};
          end else begin
            push_c = 1'b0;
          end
        end
      end
    end
  end

  assign cmd_push = acc && push_c;
  assign cmd_out  = c;

  always_ff @(posedge clk) begin
    name_rdata  <= name_store[name_raddr[$clog2(NAME_LIMIT > 1 ? NAME_LIMIT : 2)-1:0]];
    value_rdata <= value_store[value_raddr[$clog2(VALUE_LIMIT > 1 ? VALUE_LIMIT : 2)-1:0]];
    if (acc && nwr) begin
      name_store[name_len[$clog2(NAME_LIMIT > 1 ? NAME_LIMIT : 2)-1:0]] <= ch;
    end
    if (acc && vwr) begin
      value_store[value_len[$clog2(VALUE_LIMIT > 1 ? VALUE_LIMIT : 2)-1:0]] <= ch;
    end
    if (rst || (acc && reset_all)) begin
      mode      <= M_NAME;
      in_quotes <= 1'b0;
      quote_dbl <= 1'b0;
      name_len  <= 5'd0;
      value_len <= 6'd0;
      trim_len  <= 6'd0;
      dropping  <= 1'b0;
    end else if (acc) begin
      mode      <= mode_next;
      in_quotes <= in_quotes_next;
      quote_dbl <= quote_dbl_next;
      name_len  <= name_len_next;
      value_len <= value_len_next;
      trim_len  <= trim_len_next;
      dropping  <= dropping_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/header_attribute_tokenizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the header attribute tokenizer: parser, command queue, emitter.
// Depends on hat_pkg, hat_parser, hat_cmd_fifo, hat_emitter.
// A byte that produces no result is taken without a stall. A byte that finishes
// an attribute queues a command; the emitter then replays the stored name and
// value, one beat per cycle while the output is not stalled, then an end beat
// (only an error beat for an error command), and further input is stalled until
// that replay is done, since both sides share the byte stores. Output stalls
// stretch the replay. Outputs are registered.
module header_attribute_tokenizer_unit
  import hat_pkg::*;
#(
  parameter int NAME_LIMIT  = 16,
  parameter int VALUE_LIMIT = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] header_byte,
  input  wire        end_of_header,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] item_kind,
  output logic [7:0] out_byte,
  output logic [1:0] error_code,
  output logic       last_of_run
);
  cmd_t       push_cmd, head;
  logic       push, pop, full, empty, busy;
  logic [4:0] name_addr;
  logic [5:0] value_addr;
  logic [7:0] name_data, value_data;

  hat_parser #(.NAME_LIMIT(NAME_LIMIT), .VALUE_LIMIT(VALUE_LIMIT)) u_parser (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .header_byte(header_byte), .end_of_header(end_of_header),
    .emit_busy(busy), .cmd_full(full), .cmd_empty(empty),
    .cmd_push(push), .cmd_out(push_cmd),
    .name_raddr(name_addr), .name_rdata(name_data),
    .value_raddr(value_addr), .value_rdata(value_data)
  );

  hat_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd),
    .full(full), .empty(empty), .pop(pop), .head(head)
  );

  hat_emitter #(.NAME_LIMIT(NAME_LIMIT), .VALUE_LIMIT(VALUE_LIMIT)) u_emit (
    .clk(clk), .rst(rst), .cmd_empty(empty), .cmd(head), .cmd_pop(pop),
    .busy(busy), .name_addr(name_addr), .name_data(name_data),
    .value_addr(value_addr), .value_data(value_data),
    .valid(out_valid), .stall(out_stall), .item_kind(item_kind),
    .out_byte(out_byte), .error_code(error_code), .last_of_run(last_of_run)
  );
endmodule
`default_nettype wire

>>> bench/header_attribute_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for header_attribute_tokenizer_unit: directed rows, then random headers.
// Depends on hat_pkg and the tokenizer RTL; predicts every output beat in-line.
module header_attribute_tokenizer_unit_tb;
  import hat_pkg::*;

  localparam int NAME_MAX  = 16;
  localparam int VALUE_MAX = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_COUNT = 360;

  typedef enum logic [1:0] {PM_NAME = 2'd0, PM_VALUE = 2'd1, PM_IGNORE = 2'd2} pmode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoh;
    logic       has_exp;
    logic [1:0] exp_kind;
    logic [1:0] exp_code;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall, end_of_header;
  logic [7:0] header_byte;
  logic out_valid, out_stall, last_of_run;
  logic [1:0] item_kind, error_code;
  logic [7:0] out_byte;

  header_attribute_tokenizer_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .header_byte(header_byte), .end_of_header(end_of_header),
    .out_valid(out_valid), .out_stall(out_stall), .item_kind(item_kind),
    .out_byte(out_byte), .error_code(error_code), .last_of_run(last_of_run)
  );

  // predictor state
  pmode_t     p_mode;
  logic       p_quoted, p_dq, p_drop;
  logic [7:0] p_name [NAME_MAX];
  logic [7:0] p_val  [VALUE_MAX];
  int         p_nlen, p_vlen, p_vtrim;

  token_t     expected_tokens [$];
  int         mismatches;
  longint     cycles;
  int         sent_bytes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_ctl_char(logic [7:0] c);
    return c < 8'h20 || c == 8'h7F;
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c == CH_SEMI || c == CH_COMMA;
  endfunction

  task automatic clear_tokenizer();
    p_mode = PM_NAME; p_quoted = 0; p_dq = 0; p_drop = 0;
    p_nlen = 0; p_vlen = 0; p_vtrim = 0;
  endtask

  task automatic push_token(logic [1:0] k, logic [7:0] d, logic [1:0] c, logic l);
    token_t t;
    t.kind = k; t.data = d; t.code = c; t.last = l;
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  task automatic push_attribute(int vlen);
    for (int i = 0; i < p_nlen; i++) push_token(KIND_NAME, p_name[i], ERR_NAME, 1'b0);
    for (int i = 0; i < vlen; i++) push_token(KIND_VALUE, p_val[i], ERR_NAME, 1'b0);
    push_token(KIND_END, 8'h00, ERR_NAME, 1'b1);
    p_nlen = 0; p_vlen = 0; p_vtrim = 0;
  endtask

  task automatic tokenize_byte(logic [7:0] c, logic eoh);
    int err;
    logic [7:0] q;
    err = -1;
    if (p_drop) begin
      if (eoh) clear_tokenizer();
      return;
    end
    case (p_mode)
      PM_NAME: begin
        if (c == CH_EQ) begin
          p_quoted = 0; p_dq = 0; p_vlen = 0; p_vtrim = 0; p_mode = PM_VALUE;
        end else if (is_delim(c)) begin
          if (p_nlen > 0) push_attribute(0);
        end else if (!is_space(c)) begin
          if (is_ctl_char(c) || p_nlen >= NAME_MAX) err = ERR_NAME;
          else p_name[p_nlen++] = c;
        end
      end
      PM_VALUE: begin
        if (!p_quoted) begin
          if (is_delim(c)) begin
            push_attribute(p_vtrim);
            p_mode = PM_NAME;
          end else if (p_vlen == 0 && (c == CH_SQUOTE || c == CH_DQUOTE)) begin
            p_quoted = 1; p_dq = (c == CH_DQUOTE);
          end else if (c == CH_SPACE || c == CH_TAB) begin
            if (p_vlen > 0) begin
              if (p_vlen >= VALUE_MAX) err = ERR_VALUE;
              else p_val[p_vlen++] = c;
            end
          end else if (is_ctl_char(c) || p_vlen >= VALUE_MAX) begin
            err = ERR_VALUE;
          end else begin
            p_val[p_vlen++] = c;
            p_vtrim = p_vlen;
          end
        end else begin
          q = p_dq ? CH_DQUOTE : CH_SQUOTE;
          if (c == q) begin
            push_attribute(p_vlen);
            p_quoted = 0; p_dq = 0; p_mode = PM_IGNORE;
          end else if (p_vlen >= VALUE_MAX) begin
            err = ERR_QUOTED;
          end else begin
            p_val[p_vlen++] = c;
          end
        end
      end
      default: if (is_delim(c)) p_mode = PM_NAME;
    endcase
    if (err >= 0) begin
      push_token(KIND_ERROR, 8'h00, err[1:0], 1'b1);
      if (eoh) clear_tokenizer();
      else p_drop = 1;
      return;
    end
    if (eoh) begin
      if (p_nlen > 0) begin
        if (p_mode == PM_VALUE && p_quoted) push_token(KIND_ERROR, 8'h00, ERR_UNTERM, 1'b1);
        else if (p_mode == PM_NAME) push_attribute(0);
        else if (p_mode == PM_VALUE) push_attribute(p_vtrim);
      end
      clear_tokenizer();
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // receiver: stall pattern and checking of every output beat
  int stall_phase;
  always @(posedge clk) begin
    token_t t;
    if (rst) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      cycles <= cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected beat", {6'b0, item_kind}, 8'h00);
        end else begin
          t = expected_tokens.pop_front();
          if (item_kind !== t.kind) report_mismatch("item_kind", {6'b0, item_kind}, {6'b0, t.kind});
          if (out_byte !== t.data) report_mismatch("out_byte", out_byte, t.data);
          if (error_code !== t.code)
            report_mismatch("error_code", {6'b0, error_code}, {6'b0, t.code});
          if (last_of_run !== t.last)
            report_mismatch("last_of_run", {7'b0, last_of_run}, {7'b0, t.last});
        end
      end
      stall_phase <= stall_phase + 1;
      // long quiet stretches, then bursts of heavy back-pressure, then lighter back-pressure
      if (stall_phase % 400 < 150) out_stall <= 1'b0;
      else if (stall_phase % 400 < 250) out_stall <= ($urandom_range(0, 3) != 0);
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  int gap_left, burst_left;

  // hold the byte until it is taken, with bursts and gaps between beats
  task automatic send_byte(logic [7:0] c, logic eoh);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left = 1;
    end
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      while (gap_left > 0) begin
        @(posedge clk);
        gap_left--;
      end
    end
    in_valid <= 1'b1;
    header_byte <= c;
    end_of_header <= eoh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(c, eoh);
    sent_bytes++;
    burst_left--;
  endtask

  function automatic logic [7:0] pick_char(int kind);
    case (kind)
      0: return 8'(8'h61 + $urandom_range(0, 25));
      1: return CH_SPACE;
      2: return CH_TAB;
      3: return 8'($urandom_range(0, 255));
      default: return 8'(8'h30 + $urandom_range(0, 9));
    endcase
  endfunction

  task automatic send_header_random();
    int nattr, nlen, vlen, style;
    logic [7:0] c;
    nattr = $urandom_range(1, 3);
    for (int a = 0; a < nattr; a++) begin
      nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      for (int i = 0; i < nlen; i++)
        send_byte(($urandom_range(0, 7) == 0) ? pick_char(1) : pick_char(0), 1'b0);
      style = $urandom_range(0, 5);
      if (style != 0) send_byte(CH_EQ, 1'b0);
      vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
      if (style == 4 || style == 5) begin
        c = (style == 4) ? CH_DQUOTE : CH_SQUOTE;
        if ($urandom_range(0, 1)) send_byte(CH_SPACE, 1'b0);
        send_byte(c, 1'b0);
        for (int i = 0; i < vlen; i++)
          send_byte(($urandom_range(0, 9) == 0) ? pick_char(3) : pick_char(0), 1'b0);
        if ($urandom_range(0, 7) != 0) send_byte(c, 1'b0);
        if ($urandom_range(0, 2) == 0) send_byte(pick_char(4), 1'b0);
      end else if (style != 0) begin
        for (int i = 0; i < vlen; i++)
          send_byte(pick_char($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 4)), 1'b0);
      end
      if (a != nattr - 1) send_byte($urandom_range(0, 1) ? CH_SEMI : CH_COMMA, 1'b0);
      else if ($urandom_range(0, 3) == 0) send_byte(CH_SEMI, 1'b0);
    end
    send_byte(($urandom_range(0, 4) == 0) ? pick_char(3) : pick_char(0), 1'b1);
  endtask

  row_t directed_rows [] = '{
    // name "a", value "b", end of header
    '{8'h61, 1'b0, 1'b0, 2'd0, 2'd0}, '{CH_EQ, 1'b0, 1'b0, 2'd0, 2'd0},
    '{8'h62, 1'b1, 1'b0, 2'd0, 2'd0},
    // control byte in a name
    '{8'h00, 1'b0, 1'b1, KIND_ERROR, ERR_NAME}, '{8'hFF, 1'b1, 1'b0, 2'd0, 2'd0},
    // control byte in an unquoted value, on the final byte
    '{8'h78, 1'b0, 1'b0, 2'd0, 2'd0}, '{CH_EQ, 1'b0, 1'b0, 2'd0, 2'd0},
    '{8'h7F, 1'b1, 1'b1, KIND_ERROR, ERR_VALUE},
    // unterminated quote
    '{8'h71, 1'b0, 1'b0, 2'd0, 2'd0}, '{CH_EQ, 1'b0, 1'b0, 2'd0, 2'd0},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, 2'd0}, '{8'h01, 1'b1, 1'b1, KIND_ERROR, ERR_UNTERM},
    // valueless attribute, empty name delimiters, missing name, ignored tail
    '{8'h6B, 1'b0, 1'b0, 2'd0, 2'd0}, '{CH_COMMA, 1'b0, 1'b0, 2'd0, 2'd0},
    '{CH_SEMI, 1'b0, 1'b0, 2'd0, 2'd0}, '{CH_EQ, 1'b0, 1'b0, 2'd0, 2'd0},
    '{CH_SQUOTE, 1'b0, 1'b0, 2'd0, 2'd0}, '{8'hFE, 1'b0, 1'b0, 2'd0, 2'd0},
    '{CH_SQUOTE, 1'b0, 1'b0, 2'd0, 2'd0}, '{8'h7A, 1'b0, 1'b0, 2'd0, 2'd0},
    '{CH_TAB, 1'b0, 1'b0, 2'd0, 2'd0}, '{8'h0D, 1'b1, 1'b0, 2'd0, 2'd0}
  };

  initial begin
    token_t head;
    row_t r;
    in_valid = 1'b0; header_byte = 8'h00; end_of_header = 1'b0;
    out_stall = 1'b0; mismatches = 0; cycles = 0; sent_bytes = 0;
    burst_left = 0; gap_left = 0;
    clear_tokenizer();
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_byte(r.data, r.eoh);
      if (r.has_exp) begin
        head = expected_tokens[expected_tokens.size() - 1];
        if (head.kind !== r.exp_kind || head.code !== r.exp_code)
          report_mismatch("directed prediction", {6'b0, head.code}, {6'b0, r.exp_code});
      end
    end

    // overlong name, overlong unquoted value, overlong quoted value
    for (int i = 0; i < 17; i++) send_byte(8'h6E, i == 16);
    send_byte(8'h76, 1'b0); send_byte(CH_EQ, 1'b0);
    for (int i = 0; i < 33; i++) send_byte((i % 2) ? CH_SPACE : 8'h77, i == 32);
    send_byte(8'h76, 1'b0); send_byte(CH_EQ, 1'b0); send_byte(CH_DQUOTE, 1'b0);
    for (int i = 0; i < 33; i++) send_byte(8'(8'h80 + i), i == 32);

    // drain completely before resuming
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);

    while (sent_bytes < ITEM_COUNT) send_header_random();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
